### rtl/tsr_pkg.sv
package tsr_pkg;

    localparam int COL_W  = 7;
    localparam int ROW_W  = 6;
    localparam int LEN_W  = 8;
    localparam int CLR_W  = 24;
    localparam int DX_W   = COL_W + 1;
    localparam int ACC_W  = 14;
    localparam int NUM_W  = ACC_W - 1;
    localparam int QUO_W  = COL_W;
    localparam int CNT_W  = 3;

    typedef struct packed {
        logic [COL_W-1:0] ax;
        logic [ROW_W-1:0] ay;
        logic [COL_W-1:0] bx;
        logic [ROW_W-1:0] by;
        logic [COL_W-1:0] cx;
        logic [ROW_W-1:0] cy;
        logic [CLR_W-1:0] fill_colour;
    } vert_t;

    typedef struct packed {
        logic [COL_W-1:0] span_x;
        logic [ROW_W-1:0] span_row;
        logic [LEN_W-1:0] span_len;
        logic [CLR_W-1:0] span_colour;
        logic             last_span;
    } span_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [ROW_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [QUO_W-1:0] quo;
    } div_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SORT,
        ST_SETUP,
        ST_DIV_A,
        ST_WAIT_A,
        ST_DIV_B,
        ST_WAIT_B,
        ST_EMIT
    } tsr_state_t;

endpackage

### rtl/tsr_div.sv
module tsr_div (
    input  logic              clk,
    input  logic              rst_n,
    input  tsr_pkg::div_req_t req,
    output tsr_pkg::div_rsp_t rsp
);
    import tsr_pkg::*;

    localparam int D_W = NUM_W;

    logic [NUM_W-1:0] rem_reg, rem_next;
    logic [D_W-1:0]   dvs_reg, dvs_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [NUM_W:0]   trial;

    // quotient is known to fit in QUO_W bits, so only QUO_W restoring steps
    always_comb
    begin
        trial     = {1'b0, rem_reg} - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next = req.num;
            dvs_next = D_W'({req.den, {(QUO_W-1){1'b0}}});
            quo_next = '0;
            cnt_next = CNT_W'(QUO_W);
        end
        else if (cnt_reg != '0)
        begin
            if (!trial[NUM_W])
            begin
                rem_next = trial[NUM_W-1:0];
            end
            quo_next  = {quo_reg[QUO_W-2:0], ~trial[NUM_W]};
            dvs_next  = dvs_reg >> 1;
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign rsp.busy = (cnt_reg != '0);
    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

### rtl/triangle_span_rasterizer.sv
// channel | signals                        | word
// --------+--------------------------------+------------------------------
// input   | vert_valid, vert_ready, vert   | one triangle: 3 vertices, colour
// output  | span_valid, span_ready, span   | one span per scanline
//
// One triangle at a time: sort, setup, then for each row two passes through the
// shared restoring divider (one per edge) followed by an emit step. A flat
// triangle (all vertices on one row) goes straight from setup to emit.
// vert_ready is high only while idle. The span output register lets the next
// row compute while a span waits; a stalled sink stops the sequencer at emit.
// Reset (rst_n, async) clears the sequencer, divider count and output valid.
module triangle_span_rasterizer #(
    parameter int ROWS = 64,
    parameter int COLS = 128
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           vert_valid,
    output logic           vert_ready,
    input  tsr_pkg::vert_t vert,
    output logic           span_valid,
    input  logic           span_ready,
    output tsr_pkg::span_t span
);
    import tsr_pkg::*;

    localparam logic [COL_W-1:0] X_MAX = (COLS - 1 > 127) ? COL_W'(127) : COL_W'(COLS - 1);
    localparam logic [ROW_W-1:0] Y_MAX = (ROWS - 1 > 63) ? ROW_W'(63) : ROW_W'(ROWS - 1);

    tsr_state_t state_reg, state_next;
    vert_t      in_reg;

    logic [COL_W-1:0] x0_reg, x1_reg, x2_reg;
    logic [ROW_W-1:0] y0_reg, y1_reg, y2_reg;
    logic signed [ACC_W-1:0] sa_reg, sb_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] a_reg, b_reg;
    logic             degen_reg;
    span_t            span_reg;
    logic             span_valid_reg;

    div_req_t dreq;
    div_rsp_t drsp;

    // sort network signals
    logic [COL_W-1:0] cx_a, cx_b, cx_c, sx0, sx1, sx2, tx;
    logic [ROW_W-1:0] cy_a, cy_b, cy_c, sy0, sy1, sy2, ty;

    logic signed [DX_W-1:0] dx01, dx02, dx12, step_a;
    logic [ROW_W-1:0] dy01, dy02, dy12;
    logic             flat_bot, upper, load_out, is_last;
    logic [ROW_W:0]   row_inc;
    logic signed [ACC_W-1:0] mag_a, mag_b;
    logic [COL_W-1:0] base_a, lo, hi, mn, mx;
    logic signed [COL_W+1:0] q_ext, val;
    logic [COL_W-1:0] new_col;

    tsr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    // clamp and stable three-way sort by row
    always_comb
    begin
        tx = '0;
        ty = '0;
        cx_a = (in_reg.ax > X_MAX) ? X_MAX : in_reg.ax;
        cy_a = (in_reg.ay > Y_MAX) ? Y_MAX : in_reg.ay;
        cx_b = (in_reg.bx > X_MAX) ? X_MAX : in_reg.bx;
        cy_b = (in_reg.by > Y_MAX) ? Y_MAX : in_reg.by;
        cx_c = (in_reg.cx > X_MAX) ? X_MAX : in_reg.cx;
        cy_c = (in_reg.cy > Y_MAX) ? Y_MAX : in_reg.cy;
        sx0 = cx_a; sy0 = cy_a;
        sx1 = cx_b; sy1 = cy_b;
        sx2 = cx_c; sy2 = cy_c;
        if (sy0 > sy1)
        begin
            tx = sx0; ty = sy0; sx0 = sx1; sy0 = sy1; sx1 = tx; sy1 = ty;
        end
        if (sy1 > sy2)
        begin
            tx = sx1; ty = sy1; sx1 = sx2; sy1 = sy2; sx2 = tx; sy2 = ty;
        end
        if (sy0 > sy1)
        begin
            tx = sx0; ty = sy0; sx0 = sx1; sy0 = sy1; sx1 = tx; sy1 = ty;
        end
    end

    always_comb
    begin
        dx01 = $signed({1'b0, x1_reg}) - $signed({1'b0, x0_reg});
        dx02 = $signed({1'b0, x2_reg}) - $signed({1'b0, x0_reg});
        dx12 = $signed({1'b0, x2_reg}) - $signed({1'b0, x1_reg});
        dy01 = y1_reg - y0_reg;
        dy02 = y2_reg - y0_reg;
        dy12 = y2_reg - y1_reg;
        flat_bot = (y1_reg == y2_reg);
        upper    = (row_reg < y1_reg) || flat_bot;
        step_a   = upper ? dx01 : dx12;
        base_a   = upper ? x0_reg : x1_reg;
        row_inc  = {1'b0, row_reg} + (ROW_W+1)'(1);
        mag_a    = sa_reg[ACC_W-1] ? -sa_reg : sa_reg;
        mag_b    = sb_reg[ACC_W-1] ? -sb_reg : sb_reg;

        mn = x0_reg;
        mx = x0_reg;
        if (x1_reg < mn) mn = x1_reg;
        if (x1_reg > mx) mx = x1_reg;
        if (x2_reg < mn) mn = x2_reg;
        if (x2_reg > mx) mx = x2_reg;

        lo = (a_reg < b_reg) ? a_reg : b_reg;
        hi = (a_reg < b_reg) ? b_reg : a_reg;
        is_last  = degen_reg || (row_reg == y2_reg);
        load_out = !span_valid_reg || span_ready;
    end

    // column = base + trunc(acc / dy), sign applied after the unsigned divide
    always_comb
    begin
        q_ext = $signed({2'b00, drsp.quo});
        if (state_reg == ST_WAIT_B)
        begin
            if (sb_reg[ACC_W-1]) q_ext = -q_ext;
            val = $signed({2'b00, x0_reg}) + q_ext;
        end
        else
        begin
            if (sa_reg[ACC_W-1]) q_ext = -q_ext;
            val = $signed({2'b00, base_a}) + q_ext;
        end
        new_col = val[COL_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        dreq.start = 1'b0;
        dreq.num   = mag_a[NUM_W-1:0];
        dreq.den   = upper ? dy01 : dy12;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (vert_valid) state_next = ST_SORT;
            end
            ST_SORT:  state_next = ST_SETUP;
            ST_SETUP:
            begin
                state_next = (y0_reg == y2_reg) ? ST_EMIT : ST_DIV_A;
            end
            ST_DIV_A:
            begin
                dreq.start = 1'b1;
                state_next = ST_WAIT_A;
            end
            ST_WAIT_A:
            begin
                if (drsp.done) state_next = ST_DIV_B;
            end
            ST_DIV_B:
            begin
                dreq.start = 1'b1;
                dreq.num   = mag_b[NUM_W-1:0];
                dreq.den   = dy02;
                state_next = ST_WAIT_B;
            end
            ST_WAIT_B:
            begin
                if (drsp.done) state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (load_out) state_next = is_last ? ST_IDLE : ST_DIV_A;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            span_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_EMIT && load_out)
            begin
                span_valid_reg <= 1'b1;
            end
            else if (span_ready)
            begin
                span_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && vert_valid)
        begin
            in_reg <= vert;
        end
        if (state_reg == ST_SORT)
        begin
            x0_reg <= sx0; y0_reg <= sy0;
            x1_reg <= sx1; y1_reg <= sy1;
            x2_reg <= sx2; y2_reg <= sy2;
        end
        if (state_reg == ST_SETUP)
        begin
            sa_reg    <= '0;
            sb_reg    <= '0;
            row_reg   <= y0_reg;
            degen_reg <= (y0_reg == y2_reg);
            a_reg     <= mn;
            b_reg     <= mx;
        end
        if (state_reg == ST_WAIT_A && drsp.done)
        begin
            a_reg <= new_col;
        end
        if (state_reg == ST_WAIT_B && drsp.done)
        begin
            b_reg <= new_col;
        end
        if (state_reg == ST_EMIT && load_out)
        begin
            span_reg.span_x      <= lo;
            span_reg.span_row    <= row_reg;
            span_reg.span_len    <= LEN_W'(hi - lo) + LEN_W'(1);
            span_reg.span_colour <= in_reg.fill_colour;
            span_reg.last_span   <= is_last;
            row_reg              <= row_inc[ROW_W-1:0];
            sb_reg               <= sb_reg + ACC_W'(dx02);
            // entering the lower part restarts the accumulator of the lower edge (from y1 to y2)
            if (!flat_bot && row_inc == {1'b0, y1_reg})
            begin
                sa_reg <= '0;
            end
            else
            begin
                sa_reg <= sa_reg + ACC_W'(step_a);
            end
        end
    end

    assign vert_ready = (state_reg == ST_IDLE);
    assign span_valid = span_valid_reg;
    assign span       = span_reg;

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !drsp.busy)
        else $error("divider busy while sequencer idle");

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        span_valid |-> (span.span_len != '0))
        else $error("span with zero length");

    a_span_fits: assert property (@(posedge clk) disable iff (!rst_n)
        span_valid |-> (({2'b00, span.span_x} + {1'b0, span.span_len}) <= 10'd128))
        else $error("span runs past the last column");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (vert_valid && vert_ready) |=> !vert_ready)
        else $error("ready again right after accepting a triangle");

endmodule

### verif/tb.sv
`timescale 1ns / 100ps

module tb;
    import tsr_pkg::*;

    localparam int ROWS        = 64;
    localparam int COLS        = 128;
    localparam int STALL_LIMIT = 6000;
    localparam int HOLD_CYCLES = 500;
    localparam int HOLD_AT     = 200;
    localparam int N_RANDOM    = 250;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_HALF,
        RX_SPARSE,
        RX_BURSTY
    } rx_mode_t;

    typedef enum logic [1:0] {
        TRI_SMALL,
        TRI_WIDE,
        TRI_FLAT,
        TRI_TIE
    } tri_kind_t;

    logic  clk        = 1'b0;
    logic  rst_n      = 1'b0;
    logic  vert_valid = 1'b0;
    logic  vert_ready;
    vert_t vert       = '0;
    logic  span_valid;
    logic  span_ready = 1'b0;
    span_t span;

    vert_t queued_tris[$];
    bit    drain_first[$];
    span_t pending_spans[$];

    int err_cnt      = 0;
    int burst_left   = 0;
    int gap_left     = 0;
    int spans_seen   = 0;
    int hold_left    = 0;
    int mode_left    = 0;
    int idle_cycles  = 0;
    rx_mode_t rx_mode = RX_FREE;

    triangle_span_rasterizer #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .vert_valid (vert_valid),
        .vert_ready (vert_ready),
        .vert       (vert),
        .span_valid (span_valid),
        .span_ready (span_ready),
        .span       (span)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic int col_lim(input int v);
        return (v > COLS - 1) ? COLS - 1 : v;
    endfunction

    function automatic int row_lim(input int v);
        return (v > ROWS - 1) ? ROWS - 1 : v;
    endfunction

    function automatic void push_span(input int a, input int b, input int row,
                                      input logic [CLR_W-1:0] colour, input bit last);
        span_t s;
        int    t;
        if (a > b)
        begin
            t = a;
            a = b;
            b = t;
        end
        s.span_x      = COL_W'(a);
        s.span_row    = ROW_W'(row);
        s.span_len    = LEN_W'(b - a + 1);
        s.span_colour = colour;
        s.last_span   = last;
        pending_spans.push_back(s);
    endfunction

    // all spans of one triangle, top row first
    function automatic void predict_spans(input vert_t tri_w);
        int px[3];
        int py[3];
        int i, t, lo, hi, row, last_row, acc_a, acc_b;
        int dx01, dy01, dx02, dy02, dx12, dy12;
        px[0] = col_lim(tri_w.ax);
        py[0] = row_lim(tri_w.ay);
        px[1] = col_lim(tri_w.bx);
        py[1] = row_lim(tri_w.by);
        px[2] = col_lim(tri_w.cx);
        py[2] = row_lim(tri_w.cy);
        // stable sort by row: pairs 0-1, 1-2, 0-1
        for (int k = 0; k < 3; k++)
        begin
            i = k % 2;
            if (py[i] > py[i+1])
            begin
                t = py[i]; py[i] = py[i+1]; py[i+1] = t;
                t = px[i]; px[i] = px[i+1]; px[i+1] = t;
            end
        end
        if (py[0] == py[2])
        begin
            lo = px[0];
            hi = px[0];
            for (int k = 1; k < 3; k++)
            begin
                if (px[k] < lo) lo = px[k];
                if (px[k] > hi) hi = px[k];
            end
            push_span(lo, hi, py[0], tri_w.fill_colour, 1'b1);
            return;
        end
        dx01 = px[1] - px[0]; dy01 = py[1] - py[0];
        dx02 = px[2] - px[0]; dy02 = py[2] - py[0];
        dx12 = px[2] - px[1]; dy12 = py[2] - py[1];
        // row y1 goes with the upper part only when the bottom is flat
        last_row = (py[1] == py[2]) ? py[1] : py[1] - 1;
        acc_a = 0;
        acc_b = 0;
        row = py[0];
        while (row <= last_row)
        begin
            push_span(px[0] + acc_a / dy01, px[0] + acc_b / dy02, row,
                      tri_w.fill_colour, row == py[2]);
            acc_a += dx01;
            acc_b += dx02;
            row++;
        end
        acc_a = dx12 * (row - py[1]);
        acc_b = dx02 * (row - py[0]);
        while (row <= py[2])
        begin
            push_span(px[1] + acc_a / dy12, px[0] + acc_b / dy02, row,
                      tri_w.fill_colour, row == py[2]);
            acc_a += dx12;
            acc_b += dx02;
            row++;
        end
    endfunction

    task automatic add_tri(input int ax, input int ay, input int bx, input int by,
                           input int cx, input int cy, input logic [CLR_W-1:0] colour,
                           input bit drain);
        vert_t v;
        v.ax          = COL_W'(ax);
        v.ay          = ROW_W'(ay);
        v.bx          = COL_W'(bx);
        v.by          = ROW_W'(by);
        v.cx          = COL_W'(cx);
        v.cy          = ROW_W'(cy);
        v.fill_colour = colour;
        queued_tris.push_back(v);
        drain_first.push_back(drain);
    endtask

    task automatic add_random_tri(input bit drain);
        tri_kind_t kind;
        int        pick, base, y0, y1, y2;
        logic [CLR_W-1:0] colour;
        pick   = $urandom_range(0, 99);
        colour = CLR_W'($urandom());
        kind   = (pick < 55) ? TRI_SMALL : (pick < 80) ? TRI_WIDE :
                 (pick < 90) ? TRI_FLAT : TRI_TIE;
        base   = $urandom_range(0, 63);
        case (kind)
            TRI_SMALL:
            begin
                y0 = row_lim(base + $urandom_range(0, 7));
                y1 = row_lim(base + $urandom_range(0, 7));
                y2 = row_lim(base + $urandom_range(0, 7));
            end
            TRI_WIDE:
            begin
                y0 = $urandom_range(0, 63);
                y1 = $urandom_range(0, 63);
                y2 = $urandom_range(0, 63);
            end
            TRI_FLAT:
            begin
                y0 = base;
                y1 = base;
                y2 = base;
            end
            default:
            begin
                // two vertices share a row, the third is nearby
                y0 = base;
                y1 = row_lim(base + $urandom_range(1, 10));
                y2 = $urandom_range(0, 1) ? base : y1;
            end
        endcase
        add_tri($urandom_range(0, 127), y0, $urandom_range(0, 127), y1,
                $urandom_range(0, 127), y2, colour, drain);
    endtask

    // driver: bursts of words with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        vert_t nxt_word;
        logic  nxt_valid;
        if (!rst_n)
        begin
            vert_valid <= 1'b0;
            vert       <= '0;
        end
        else
        begin
            nxt_word  = vert;
            nxt_valid = 1'b0;
            if (vert_valid && vert_ready)
                predict_spans(vert);
            if (vert_valid && !vert_ready)
                nxt_valid = 1'b1;
            else if (gap_left > 0)
                gap_left--;
            else if (queued_tris.size() > 0 &&
                     !(drain_first[0] && pending_spans.size() != 0))
            begin
                nxt_word  = queued_tris.pop_front();
                void'(drain_first.pop_front());
                nxt_valid = 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 12);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                end
            end
            vert_valid <= nxt_valid;
            vert       <= nxt_word;
        end
    end

    // monitor: checks each span word and drives the sink stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        span_t want;
        logic  nxt_ready;
        if (!rst_n)
            span_ready <= 1'b0;
        else
        begin
            if (span_valid && span_ready)
            begin
                spans_seen++;
                if (spans_seen == HOLD_AT)
                    hold_left = HOLD_CYCLES;
                if (pending_spans.size() == 0)
                begin
                    $error("unexpected span: x %0d row %0d len %0d",
                           span.span_x, span.span_row, span.span_len);
                    err_cnt++;
                end
                else
                begin
                    want = pending_spans.pop_front();
                    if (span.span_x !== want.span_x)
                    begin
                        $error("span_x: expected %0d, got %0d", want.span_x, span.span_x);
                        err_cnt++;
                    end
                    if (span.span_row !== want.span_row)
                    begin
                        $error("span_row: expected %0d, got %0d",
                               want.span_row, span.span_row);
                        err_cnt++;
                    end
                    if (span.span_len !== want.span_len)
                    begin
                        $error("span_len: expected %0d, got %0d",
                               want.span_len, span.span_len);
                        err_cnt++;
                    end
                    if (span.span_colour !== want.span_colour)
                    begin
                        $error("span_colour: expected %h, got %h",
                               want.span_colour, span.span_colour);
                        err_cnt++;
                    end
                    if (span.last_span !== want.last_span)
                    begin
                        $error("last_span: expected %0d, got %0d",
                               want.last_span, span.last_span);
                        err_cnt++;
                    end
                end
            end
            if (mode_left == 0)
            begin
                rx_mode   = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(32, 256);
            end
            else
                mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                nxt_ready = 1'b0;
            end
            else
            begin
                case (rx_mode)
                    RX_FREE:   nxt_ready = 1'b1;
                    RX_HALF:   nxt_ready = $urandom_range(0, 1);
                    RX_SPARSE: nxt_ready = ($urandom_range(0, 3) == 0);
                    default:   nxt_ready = ($urandom_range(0, 7) != 0);
                endcase
            end
            span_ready <= nxt_ready;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (vert_valid && vert_ready) || (span_valid && span_ready))
            idle_cycles <= 0;
        else if (idle_cycles == STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        // single-row triangles, extremes of x and colour
        add_tri(0, 0, 0, 0, 0, 0, 24'h000000, 1'b0);
        add_tri(0, 63, 127, 63, 64, 63, 24'hFFFFFF, 1'b0);
        add_tri(127, 63, 127, 63, 127, 63, 24'hAAAAAA, 1'b0);
        add_tri(30, 20, 90, 20, 10, 20, 24'h555555, 1'b0);
        // full-height flat bottom and flat top
        add_tri(0, 0, 127, 63, 0, 63, 24'h123456, 1'b0);
        add_tri(0, 0, 127, 0, 64, 63, 24'hFEDCBA, 1'b0);
        // steep and reversed slopes
        add_tri(127, 0, 127, 63, 0, 32, 24'h0F0F0F, 1'b0);
        add_tri(127, 0, 0, 63, 127, 63, 24'hF0F0F0, 1'b0);
        add_tri(64, 63, 0, 0, 127, 31, 24'h800001, 1'b0);
        // same triangle in several vertex orders
        add_tri(10, 5, 40, 20, 25, 40, 24'h111111, 1'b0);
        add_tri(40, 20, 25, 40, 10, 5, 24'h222222, 1'b0);
        add_tri(25, 40, 10, 5, 40, 20, 24'h333333, 1'b0);
        add_tri(25, 40, 40, 20, 10, 5, 24'h444444, 1'b0);
        // equal rows on top and on bottom, both orders
        add_tri(5, 10, 100, 10, 50, 30, 24'h010203, 1'b0);
        add_tri(100, 10, 5, 10, 50, 30, 24'h040506, 1'b0);
        add_tri(50, 10, 5, 30, 100, 30, 24'h070809, 1'b0);
        add_tri(50, 10, 100, 30, 5, 30, 24'h0A0B0C, 1'b0);
        // two rows high
        add_tri(0, 10, 127, 11, 60, 10, 24'h7FFFFF, 1'b0);
        add_tri(127, 62, 0, 63, 3, 63, 24'hC0FFEE, 1'b0);
        // collinear and coincident points
        add_tri(0, 0, 63, 31, 126, 62, 24'h00FF00, 1'b0);
        add_tri(20, 5, 20, 5, 90, 50, 24'h0000FF, 1'b0);
        for (int i = 0; i < N_RANDOM; i++)
            add_random_tri(i == 90 || i == 180);
        while (queued_tris.size() != 0 || vert_valid || pending_spans.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (err_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

endmodule

### triangle_span_rasterizer.f
rtl/tsr_pkg.sv
rtl/tsr_div.sv
rtl/triangle_span_rasterizer.sv
verif/tb.sv
